// File: hw/rtl/texture_coordinate_scroller_defines.svh
// Assertion helpers for the texture coordinate scroller
`ifndef TEXTURE_COORDINATE_SCROLLER_DEFINES_SVH
`define TEXTURE_COORDINATE_SCROLLER_DEFINES_SVH
// a condition implies another in the same cycle
`define TCS_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tcs check failed");
// a condition implies another in the next cycle
`define TCS_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tcs check failed");
`endif

// File: hw/rtl/tcs_pkg.sv
`default_nettype none
package tcs_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxShapes   = 256;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0, REQ_LOAD_VTX = 2'd1, REQ_LOAD_SHAPE = 2'd2, REQ_READ_VTX = 2'd3
  } req_t;

  localparam logic [2:0] CFG_SPEED_U = 3'd0;
  localparam logic [2:0] CFG_SPEED_V = 3'd1;
  localparam logic [2:0] CFG_MATERIAL = 3'd2;
  localparam logic [2:0] CFG_TEX_COUNT = 3'd3;
  localparam logic [2:0] CFG_SHAPE_COUNT = 3'd4;
  localparam logic [2:0] CFG_TEX_WIDTH = 3'd5;
  localparam logic [2:0] CFG_TEX_HEIGHT = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         update_rate;
    logic               active;
    logic               block_present;
    logic [9:0]         entry_index;
    logic signed [15:0] coord_u;
    logic signed [15:0] coord_v;
    logic [10:0]        shape_base;
    logic [7:0]         shape_material;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_u;
    logic signed [15:0] out_v;
    logic               done_res;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/tcs_ram.sv
`default_nettype none
module tcs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/tcs_divider.sv
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle.
module tcs_divider import tcs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);
  logic [31:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem, num[31]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        cnt  <= 6'd32;
      end else if (busy) begin
        num <= {num[30:0], 1'b0};
        if (!trial[32]) begin
          rem <= trial[31:0];
        end else begin
          rem <= {rem[30:0], num[31]};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;
endmodule
`default_nettype wire

// File: hw/rtl/texture_coordinate_scroller.sv
// Channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_data  (in_item_t)
// out      | out_valid | out_stall | out_data (out_item_t)
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// A load passes S_READ, then S_RESULT raises out_valid; a read first takes its data in
// S_RESULT. A tick runs the correction when it fires (per axis a quotient run and a
// remainder run), then setup, then reads span start, span end and material per shape,
// and for a matching shape makes up to two passes over its span at one vertex per
// cycle, bound by the single read port of the vertex memory. Reset (rst, synchronous)
// clears control, carries, progress and registers; memories keep contents.
// in_stall is high while a transaction is in work or its result is still held.
`default_nettype none
`include "texture_coordinate_scroller_defines.svh"
module texture_coordinate_scroller import tcs_pkg::*; #(
  parameter int MAX_VERTICES = MaxVertices,
  parameter int MAX_SHAPES   = MaxShapes
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int SAW = $clog2(MAX_SHAPES + 1);
  localparam int SCW = $clog2(MAX_SHAPES + 1) + 1; // shape counter

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIVU, S_DIVV, S_SETUP, S_SH_RD, S_SH_RD2,
    S_SH_CHK, S_P1, S_P2, S_RESULT
  } state_t;

  // configuration
  logic [7:0] speed_u, speed_v, material_index;
  logic [8:0] texture_count, shape_count, tex_width, tex_height;

  // scroll state
  logic [31:0] scroll_progress;
  logic [1:0]  carry_u, carry_v;
  logic        correction_armed;

  state_t      state;
  in_item_t    item;
  logic [15:0] step_u, step_v;
  logic [31:0] extra_u, extra_v;
  logic [SCW-1:0] shp, shp_last;
  logic [10:0]    vlo, vhi, rd_ptr, wr_ptr;
  logic        wr_pend;
  logic        all_u, all_v;
  logic [5:0]  kcnt;
  logic        rd_pend;
  logic [7:0]  mat_use;
  logic        mul_phase;
  logic signed [31:0] prod_u, prod_v;

  // memories
  logic           vu_we, vv_we;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic [15:0]    vu_wdata, vv_wdata, vu_rdata, vv_rdata;
  logic           sf_we, sm_we;
  logic [SAW-1:0] sf_waddr, sf_raddr, sm_waddr, sm_raddr;
  logic [10:0]    sf_rdata;
  logic [7:0]     sm_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tcs_ram #(.Width(16), .Depth(MAX_VERTICES)) u_vu (
    .clk(clk), .we(vu_we), .waddr(v_waddr), .wdata(vu_wdata),
    .raddr(v_raddr), .rdata(vu_rdata));
  tcs_ram #(.Width(16), .Depth(MAX_VERTICES)) u_vv (
    .clk(clk), .we(vv_we), .waddr(v_waddr), .wdata(vv_wdata),
    .raddr(v_raddr), .rdata(vv_rdata));
  tcs_ram #(.Width(11), .Depth(MAX_SHAPES + 1)) u_sf (
    .clk(clk), .we(sf_we), .waddr(sf_waddr), .wdata(item.shape_base),
    .raddr(sf_raddr), .rdata(sf_rdata));
  tcs_ram #(.Width(8), .Depth(MAX_SHAPES + 1)) u_sm (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(item.shape_material),
    .raddr(sm_raddr), .rdata(sm_rdata));

  tcs_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // ranges and speed magnitudes
  logic [14:0] wu, wv;
  logic [7:0]  mag_u, mag_v;
  logic [31:0] prog_mag;
  logic        prog_neg;
  assign wu = {tex_width, 6'd0};
  assign wv = {tex_height, 6'd0};
  assign mag_u = speed_u[7] ? 8'(-speed_u) : speed_u;
  assign mag_v = speed_v[7] ? 8'(-speed_v) : speed_v;
  assign prog_neg = scroll_progress[31];
  assign prog_mag = prog_neg ? -scroll_progress : scroll_progress;

  // quotient q = range*16/mag; remainder of progress mod q needs q first,
  // so two runs per axis are needed. The shared unit below returns only
  // remainders, so q is formed by a second path: a local restoring
  // quotient of range*16 by mag in phase 0, after which the shared
  // unit takes the progress magnitude mod q in phase 1.
  logic [18:0] r16_u, r16_v;
  assign r16_u = {wu, 4'd0};
  assign r16_v = {wv, 4'd0};

  // quotient by restoring steps on a 19-bit dividend, one bit per cycle
  logic [18:0] qn, qr_num;
  logic [18:0] qrem;
  logic [4:0]  qcnt;
  logic        qbusy;
  logic [19:0] qtrial;
  assign qtrial = {qrem, qr_num[18]} - {12'd0, (state == S_DIVU) ? mag_u : mag_v};

  logic        div_phase; // 0: quotient, 1: remainder
  logic [31:0] qval;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prog_mag;
    div_req.divisor  = qval;
    if ((state == S_DIVU || state == S_DIVV) && div_phase && !div_rsp.busy
        && !div_rsp.done) begin
      div_req.start = 1'b1;
    end
  end

  // memory port control
  always_comb begin
    vu_we    = 1'b0;
    vv_we    = 1'b0;
    v_waddr  = VAW'(item.entry_index);
    vu_wdata = item.coord_u;
    vv_wdata = item.coord_v;
    v_raddr  = VAW'(item.entry_index);
    sf_we    = 1'b0;
    sm_we    = 1'b0;
    sf_waddr = SAW'(item.entry_index);
    sm_waddr = SAW'(item.entry_index);
    sf_raddr = shp[SAW-1:0];
    sm_raddr = shp[SAW-1:0];
    // span start is read in S_SH_RD, span end in S_SH_RD2
    if (state == S_SH_RD2) begin
      sf_raddr = SAW'(shp + SCW'(1));
    end
    if (state == S_P1 || state == S_P2) begin
      v_raddr = VAW'(rd_ptr);
      v_waddr = VAW'(wr_ptr);
    end
    if (state == S_P1 && wr_pend) begin
      vu_we = 1'b1; vv_we = 1'b1;
      vu_wdata = vu_rdata + step_u;
      vv_wdata = vv_rdata + step_v;
    end
    if (state == S_P2 && wr_pend) begin
      vu_we = all_u; vv_we = all_v;
      vu_wdata = ($signed(vu_rdata) > $signed({2'b0, wu})) ? vu_rdata - {1'b0, wu}
                                                           : vu_rdata + {1'b0, wu};
      vv_wdata = ($signed(vv_rdata) > $signed({2'b0, wv})) ? vv_rdata - {1'b0, wv}
                                                           : vv_rdata + {1'b0, wv};
    end
    if (state == S_READ && item.req_type == REQ_LOAD_VTX
        && 32'(item.entry_index) < MAX_VERTICES) begin
      vu_we = 1'b1; vv_we = 1'b1;
    end
    if (state == S_READ && item.req_type == REQ_LOAD_SHAPE) begin
      sf_we = 32'(item.entry_index) <= MAX_SHAPES;
      sm_we = 32'(item.entry_index) < MAX_SHAPES;
    end
  end

  logic [15:0] new_u, new_v;
  logic        out_u_ok, out_v_ok;
  assign new_u = vu_rdata + step_u;
  assign new_v = vv_rdata + step_v;
  assign out_u_ok = ($signed(new_u) > $signed({2'b0, wu}))
                 || ($signed(new_u) < -$signed({2'b0, wu}));
  assign out_v_ok = ($signed(new_v) > $signed({2'b0, wv}))
                 || ($signed(new_v) < -$signed({2'b0, wv}));

  logic [31:0] du, dv;
  assign du = {30'd0, carry_u} + 32'(prod_u);
  assign dv = {30'd0, carry_v} + 32'(prod_v);

  // a held result keeps the input closed so out_data never changes under a stall
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      speed_u          <= '0;
      speed_v          <= '0;
      material_index   <= '0;
      texture_count    <= 9'd1;
      shape_count      <= '0;
      tex_width        <= 9'd32;
      tex_height       <= 9'd32;
      scroll_progress  <= '0;
      carry_u          <= '0;
      carry_v          <= '0;
      correction_armed <= 1'b0;
      qbusy            <= 1'b0;
      div_phase        <= 1'b0;
      mul_phase        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED_U:     speed_u <= cfg_data[7:0];
          CFG_SPEED_V:     speed_v <= cfg_data[7:0];
          CFG_MATERIAL:    material_index <= cfg_data[7:0];
          CFG_TEX_COUNT:   texture_count <= cfg_data;
          CFG_SHAPE_COUNT: shape_count <= cfg_data;
          CFG_TEX_WIDTH:   tex_width <= cfg_data;
          CFG_TEX_HEIGHT:  tex_height <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            state <= S_READ;
          end
        end
        S_READ: begin
          out_data.done_res <= 1'b1;
          out_data.out_u    <= '0;
          out_data.out_v    <= '0;
          rd_pend           <= 1'b0;
          state             <= S_RESULT;
          if (item.req_type == REQ_READ_VTX
              && 32'(item.entry_index) < MAX_VERTICES) begin
            rd_pend <= 1'b1;
          end
          if (item.req_type == REQ_TICK && item.active) begin
            scroll_progress <= scroll_progress + {28'd0, item.update_rate};
            if (!item.block_present) begin
              correction_armed <= 1'b1;
            end else begin
              extra_u <= '0;
              extra_v <= '0;
              mat_use <= ({1'b0, material_index} >= texture_count) ? 8'd0
                                                                    : material_index;
              if ({1'b0, material_index} >= texture_count) begin
                material_index <= '0;
              end
              qbusy     <= 1'b0;
              div_phase <= 1'b0;
              state <= correction_armed ? S_DIVU : S_SETUP;
            end
          end
        end
        S_DIVU, S_DIVV: begin
          // phase 0: quotient of range*16 by |speed|, one bit a cycle;
          // phase 1: progress magnitude mod that quotient on the shared unit
          if (!div_phase) begin
            if (((state == S_DIVU) ? mag_u : mag_v) == 8'd0) begin
              state <= (state == S_DIVU) ? S_DIVV : S_SETUP;
            end else if (!qbusy) begin
              qbusy  <= 1'b1;
              qr_num <= (state == S_DIVU) ? r16_u : r16_v;
              qrem   <= '0;
              qn     <= '0;
              qcnt   <= 5'd19;
            end else begin
              qr_num <= {qr_num[17:0], 1'b0};
              if (!qtrial[19]) begin
                qrem <= qtrial[18:0];
                qn   <= {qn[17:0], 1'b1};
              end else begin
                qrem <= {qrem[17:0], qr_num[18]};
                qn   <= {qn[17:0], 1'b0};
              end
              qcnt <= qcnt - 5'd1;
              if (qcnt == 5'd1) begin
                qbusy <= 1'b0;
                div_phase <= 1'b1;
                qval <= {13'd0, qn[17:0], !qtrial[19]};
              end
            end
          end else begin
            if (qval == 32'd0) begin
              div_phase <= 1'b0;
              state <= (state == S_DIVU) ? S_DIVV : S_SETUP;
            end else if (div_rsp.done) begin
              if (state == S_DIVU) begin
                extra_u <= prog_neg ? -div_rsp.rem : div_rsp.rem;
              end else begin
                extra_v <= prog_neg ? -div_rsp.rem : div_rsp.rem;
              end
              div_phase <= 1'b0;
              state <= (state == S_DIVU) ? S_DIVV : S_SETUP;
            end
          end
        end
        S_SETUP: begin
          // products first, then delta and carry
          if (!mul_phase) begin
            prod_u <= 32'($signed(speed_u)) * $signed(32'(item.update_rate) + extra_u);
            prod_v <= 32'($signed(speed_v)) * $signed(32'(item.update_rate) + extra_v);
            mul_phase <= 1'b1;
          end else begin
            mul_phase <= 1'b0;
            correction_armed <= 1'b0;
            carry_u <= du[1:0];
            carry_v <= dv[1:0];
            step_u  <= du[17:2];
            step_v  <= dv[17:2];
            shp      <= '0;
            shp_last <= (32'(shape_count) > MAX_SHAPES) ? SCW'(MAX_SHAPES)
                                                        : SCW'(shape_count);
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (shp >= shp_last) begin
            state <= S_RESULT;
          end else begin
            state <= S_SH_RD2;
          end
        end
        S_SH_RD2: begin
          vlo <= sf_rdata;
          state <= S_SH_CHK;
        end
        S_SH_CHK: begin
          vhi <= (32'(sf_rdata) > MAX_VERTICES) ? 11'(MAX_VERTICES) : sf_rdata;
          rd_ptr  <= vlo;
          wr_ptr  <= vlo;
          wr_pend <= 1'b0;
          all_u   <= 1'b1;
          all_v   <= 1'b1;
          kcnt    <= '0;
          if (sm_rdata == mat_use) begin
            state <= S_P1;
          end else begin
            shp   <= shp + SCW'(1);
            state <= S_SH_RD;
          end
        end
        S_P1, S_P2: begin
          // read one vertex a cycle; write back the one read last cycle
          wr_pend <= 1'b0;
          if (rd_ptr < vhi) begin
            rd_ptr  <= rd_ptr + 1'b1;
            wr_pend <= 1'b1;
          end
          if (wr_pend) begin
            wr_ptr <= wr_ptr + 1'b1;
            if (state == S_P1 && kcnt < 6'd32) begin
              kcnt <= kcnt + 6'd1;
              if (!out_u_ok) all_u <= 1'b0;
              if (!out_v_ok) all_v <= 1'b0;
            end
          end
          if (!(rd_ptr < vhi) && !wr_pend) begin
            rd_ptr <= vlo;
            wr_ptr <= vlo;
            if (state == S_P1 && vlo < vhi && (all_u || all_v)) begin
              state <= S_P2;
            end else begin
              shp   <= shp + SCW'(1);
              state <= S_SH_RD;
            end
          end
        end
        S_RESULT: begin
          if (rd_pend) begin
            out_data.out_u <= vu_rdata;
            out_data.out_v <= vv_rdata;
            rd_pend <= 1'b0;
          end
          if (!out_valid || !out_stall) begin
            if (!rd_pend) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCS_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `TCS_ASSERT_NXT(a_result_once, clk, rst, state == S_RESULT && !rd_pend && (!out_valid || !out_stall), out_valid)
  `TCS_ASSERT_IMP(a_write_behind_read, clk, rst, state == S_P1 && wr_pend, wr_ptr < rd_ptr)
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
  import tcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 400000;  // cycles with no transaction before giving up
  localparam int FillVerts = 64;      // vertices loaded up front; spans stay inside them
  localparam int FillShapes = 40;     // shape entries 0..FillShapes loaded; counts stay at or below it

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  texture_coordinate_scroller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------
  // Scroller shadow: stores, progress, carries, correction arm, regs
  // ---------------------------------------------------------------
  logic [15:0] sh_vu [MaxVertices];
  logic [15:0] sh_vv [MaxVertices];
  logic [10:0] sh_first [MaxShapes + 1];
  logic [7:0]  sh_tag [MaxShapes];
  bit   [31:0] progress;
  bit   [1:0]  carry_u, carry_v;
  bit          armed;
  logic [7:0]  r_speed_u, r_speed_v, r_material;
  logic [8:0]  r_tex_count, r_shape_count, r_width, r_height;

  bit written [MaxVertices];   // vertex entries that may be read back
  int written_list[$];

  out_item_t coords_expected[$];
  int        errors;
  int        snd_idle_pct, rcv_stall_pct;

  // extra ticks granted by the correction on one axis
  function automatic bit [31:0] catch_up(int spd, bit [31:0] range);
    bit [31:0] mag, q, m;
    bit        neg;
    mag = (spd < 0) ? -spd : spd;
    if (mag == 0) return 0;
    q = (range * 16) / mag;
    if (q == 0) return 0;
    neg = progress[31];
    m = neg ? -progress : progress;
    m = m % q;
    return neg ? -m : m;
  endfunction

  function automatic bit out_of_range(logic [15:0] c, bit [31:0] range);
    int t;
    t = int'($signed(c));
    return (int'(range) < t) || (t < -int'(range));
  endfunction

  function automatic logic [15:0] pull_back(logic [15:0] c, bit [31:0] range);
    if (int'(range) < int'($signed(c))) return c - range[15:0];
    return c + range[15:0];
  endfunction

  function automatic void scroll_shapes(bit [3:0] rate);
    int        su, sv, lo, hi, n;
    bit [31:0] wu, wv, tu, tv, du, dv, stepu, stepv;
    bit        allu, allv;
    su = int'($signed(r_speed_u));
    sv = int'($signed(r_speed_v));
    wu = {17'd0, r_width, 6'd0};
    wv = {17'd0, r_height, 6'd0};
    tu = rate;
    tv = rate;
    if (r_material >= r_tex_count) r_material = 0;
    if (armed) begin
      tu = rate + catch_up(su, wu);
      tv = rate + catch_up(sv, wv);
      armed = 0;
    end
    du = carry_u + 32'(su) * tu;
    dv = carry_v + 32'(sv) * tv;
    carry_u = du[1:0];
    carry_v = dv[1:0];
    stepu = $signed(du) >>> 2;
    stepv = $signed(dv) >>> 2;
    n = (r_shape_count > MaxShapes) ? MaxShapes : r_shape_count;
    for (int s = 0; s < n; s++) begin
      if (sh_tag[s] != r_material) continue;
      lo = sh_first[s];
      hi = sh_first[s + 1];
      if (hi > MaxVertices) hi = MaxVertices;
      allu = 1;
      allv = 1;
      for (int v = lo; v < hi; v++) begin
        sh_vu[v] = sh_vu[v] + stepu[15:0];
        sh_vv[v] = sh_vv[v] + stepv[15:0];
        if (v - lo < 32) begin
          if (!out_of_range(sh_vu[v], wu)) allu = 0;
          if (!out_of_range(sh_vv[v], wv)) allv = 0;
        end
      end
      for (int v = lo; v < hi; v++) begin
        if (allu) sh_vu[v] = pull_back(sh_vu[v], wu);
        if (allv) sh_vv[v] = pull_back(sh_vv[v], wv);
      end
    end
  endfunction

  // apply one accepted request to the shadow and return the expected answer
  function automatic out_item_t scroller_answer(in_item_t it);
    out_item_t r;
    int        idx;
    r = '0;
    r.done_res = 1'b1;
    idx = it.entry_index;
    case (req_t'(it.req_type))
      REQ_TICK: begin
        if (it.active) begin
          progress += it.update_rate;
          if (!it.block_present) armed = 1;
          else scroll_shapes(it.update_rate);
        end
      end
      REQ_LOAD_VTX: begin
        sh_vu[idx] = it.coord_u;
        sh_vv[idx] = it.coord_v;
        if (!written[idx]) written_list.push_back(idx);
        written[idx] = 1;
      end
      REQ_LOAD_SHAPE: begin
        if (idx <= MaxShapes) sh_first[idx] = it.shape_base;
        if (idx < MaxShapes) sh_tag[idx] = it.shape_material;
      end
      default: begin
        r.out_u = sh_vu[idx];
        r.out_v = sh_vv[idx];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Driving: one transaction per call; valid is left high so that a
  // back-to-back item needs no second assignment in the same step.
  // ---------------------------------------------------------------
  task automatic send_request(in_item_t it);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    coords_expected.push_back(scroller_answer(it));
  endtask

  // drop valid, drain every result, then write a register
  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (coords_expected.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SPEED_U:     r_speed_u     = val[7:0];
      CFG_SPEED_V:     r_speed_v     = val[7:0];
      CFG_MATERIAL:    r_material    = val[7:0];
      CFG_TEX_COUNT:   r_tex_count   = val;
      CFG_SHAPE_COUNT: r_shape_count = val;
      CFG_TEX_WIDTH:   r_width       = val;
      default:         r_height      = val;
    endcase
  endtask

  task automatic load_setting(int su, int sv, int mat, int tc, int sc, int w, int h);
    write_reg(CFG_SPEED_U, {1'b0, 8'(su)});
    write_reg(CFG_SPEED_V, {1'b0, 8'(sv)});
    write_reg(CFG_MATERIAL, 9'(mat));
    write_reg(CFG_TEX_COUNT, 9'(tc));
    write_reg(CFG_SHAPE_COUNT, 9'(sc));
    write_reg(CFG_TEX_WIDTH, 9'(w));
    write_reg(CFG_TEX_HEIGHT, 9'(h));
  endtask

  function automatic in_item_t make_item(req_t kind, int idx);
    in_item_t it;
    it = '0;
    it.req_type    = kind;
    it.entry_index = 10'(idx);
    return it;
  endfunction

  function automatic in_item_t tick_item(int rate, bit act, bit present);
    in_item_t it;
    it = make_item(REQ_TICK, $urandom_range(0, 1023));
    it.update_rate   = 4'(rate);
    it.active        = act;
    it.block_present = present;
    it.coord_u       = 16'($urandom);
    it.coord_v       = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t vertex_item(int idx, logic [15:0] u, logic [15:0] v);
    in_item_t it;
    it = make_item(REQ_LOAD_VTX, idx);
    it.coord_u = u;
    it.coord_v = v;
    return it;
  endfunction

  function automatic in_item_t shape_item(int idx, int base, int tag);
    in_item_t it;
    it = make_item(REQ_LOAD_SHAPE, idx);
    it.shape_base     = 11'(base);
    it.shape_material = 8'(tag);
    return it;
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // every vertex a shape can touch and every shape entry a tick can walk
  // gets a value, so no tick ever walks into memory that was never written
  task automatic test_fill_tables();
    for (int v = 0; v < FillVerts; v++)
      send_request(vertex_item(v, 16'($urandom), 16'($urandom)));
    for (int s = 0; s <= FillShapes; s++)
      send_request(shape_item(s, $urandom_range(0, FillVerts), $urandom_range(0, 3)));
  endtask

  task automatic test_directed();
    // inactive tick, absent block arms the correction, plain tick with no shapes
    send_request(tick_item(15, 1'b0, 1'b1));
    send_request(tick_item(9, 1'b1, 1'b0));
    send_request(tick_item(0, 1'b1, 1'b1));
    // coordinate and index extremes, read back
    send_request(vertex_item(1023, 16'h8000, 16'h7fff));
    send_request(make_item(REQ_READ_VTX, 1023));
    send_request(vertex_item(FillVerts, 16'h7fff, 16'h8000));
    send_request(make_item(REQ_READ_VTX, FillVerts));
    // shape loads that are dropped, or keep only the span end
    send_request(shape_item(1023, 2047, 255));
    send_request(shape_item(MaxShapes + 1, 1024, 128));
    send_request(shape_item(MaxShapes, FillVerts, 255));
    // fastest speeds, narrowest textures: correction fires, wraps everywhere
    load_setting(127, -128, 1, 4, 32, 1, 1);
    send_request(tick_item(12, 1'b1, 1'b0));
    send_request(tick_item(15, 1'b1, 1'b1));
    send_request(tick_item(3, 1'b1, 1'b1));
    for (int v = 0; v < 6; v++) send_request(make_item(REQ_READ_VTX, v));
    // material beyond texture count falls back to material zero
    load_setting(-1, 1, 200, 3, 16, 256, 256);
    send_request(tick_item(1, 1'b1, 1'b1));
    send_request(make_item(REQ_READ_VTX, 0));
  endtask

  task automatic test_random(int count);
    in_item_t it;
    int       pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        it = tick_item($urandom_range(0, 15), $urandom_range(0, 9) != 0,
                       $urandom_range(0, 6) != 0);
      end else if (pick < 50) begin
        // near-range coordinates keep the wrap test busy
        if ($urandom_range(0, 1))
          it = vertex_item($urandom_range(0, FillVerts - 1),
                           16'($signed($urandom_range(0, 640)) - 320),
                           16'($signed($urandom_range(0, 640)) - 320));
        else
          it = vertex_item($urandom_range(0, 1023), 16'($urandom), 16'($urandom));
      end else if (pick < 65) begin
        if ($urandom_range(0, 3) != 0)
          it = shape_item($urandom_range(0, MaxShapes), $urandom_range(0, FillVerts),
                          $urandom_range(0, 3));
        else
          it = shape_item($urandom_range(MaxShapes + 1, 1023), $urandom_range(0, 2047),
                          $urandom_range(0, 255));
      end else begin
        it = make_item(REQ_READ_VTX, written_list[$urandom_range(0, written_list.size() - 1)]);
      end
      send_request(it);
    end
  endtask

  task automatic test_settings_sweep();
    // sender idles, receiver stalls hard
    snd_idle_pct = 12; rcv_stall_pct = 82;
    load_setting(0, 0, 0, 1, 0, 32, 32);
    test_random(30);
    load_setting(-128, 127, 255, 256, FillShapes, 256, 1);
    test_random(20);
    // the other way round
    snd_idle_pct = 82; rcv_stall_pct = 12;
    load_setting(37, -90, 2, 3, FillShapes, 2, 5);
    test_random(30);
    load_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3),
                 $urandom_range(1, 4), $urandom_range(0, FillShapes), $urandom_range(1, 8),
                 $urandom_range(1, 8));
    test_random(25);
    // full throughput
    snd_idle_pct = 0; rcv_stall_pct = 0;
    load_setting(1, -1, 0, 1, FillShapes, 1, 256);
    test_random(30);
    load_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3),
                 $urandom_range(1, 4), $urandom_range(0, FillShapes), $urandom_range(1, 16),
                 $urandom_range(1, 16));
    test_random(30);
  endtask

  // ---------------------------------------------------------------
  // Result checking: every out transaction against the oldest answer
  // ---------------------------------------------------------------
  out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (coords_expected.size() == 0) begin
        $error("unexpected result u=%h v=%h", out_data.out_u, out_data.out_v);
        errors++;
      end else begin
        want = coords_expected.pop_front();
        if (out_data.out_u !== want.out_u) begin
          $error("out_u expected %h actual %h", want.out_u, out_data.out_u);
          errors++;
        end
        if (out_data.out_v !== want.out_v) begin
          $error("out_v expected %h actual %h", want.out_v, out_data.out_v);
          errors++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res expected %b actual %b", want.done_res, out_data.done_res);
          errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

  // watchdog: cycles without any transaction on either channel
  int quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > IdleLimit) begin
      $display("texture_coordinate_scroller verification failed");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    errors = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    progress = 0; carry_u = 0; carry_v = 0; armed = 0;
    r_speed_u = 0; r_speed_v = 0; r_material = 0;
    r_tex_count = 1; r_shape_count = 0; r_width = 32; r_height = 32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_tables();
    test_directed();
    test_settings_sweep();

    in_valid <= 1'b0;
    @(posedge clk);
    while (coords_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("texture_coordinate_scroller verification clean");
    else $display("texture_coordinate_scroller verification failed");
    $finish;
  end
endmodule
`default_nettype wire
